// File: src/sha256_pkg.sv
// SHA-256 stream hasher package: transaction types, round constants, initial hash values.
// Used by sha256_byte_stream_hasher; no dependencies.
`timescale 1ns / 1ps
package sha256_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] f_round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[idx];
    endfunction

    function automatic logic [31:0] f_init_h(input logic [2:0] idx);
        logic [31:0] h [8];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[idx];
    endfunction

endpackage

// File: src/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher top level: byte packing, message schedule, compression, digest out.
// Depends on sha256_pkg.
// A data byte is taken while idle; the 64th byte of a block starts a compression: the 16
// words are loaded through the registered read port (S_LOAD), the rounds run one round per
// cycle (S_ROUND) and a chaining update follows (S_ADD). o_stall holds input off until the
// compression is done, so no new byte is taken meanwhile.
// A finish at fill f pads the rest of the block in S_PAD and compresses it; when f >= 56 a
// second padded block follows and is compressed. It then emits 8 digest transactions (one a cycle
// when not stalled). Reset (synchronous, active low) restores the initial hash values,
// clears the fill and byte count; the block buffer memory is not cleared.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher
    import sha256_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    typedef enum logic [3:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_EMIT
    } t_state;

    // Block buffer memory: 16 big-endian words, byte lanes written individually.
    logic [31:0] buf_mem [16];
    logic [31:0] r_buf_rd;
    // Message schedule window: 16 words, a shift line.
    logic [31:0] r_w [16];

    t_state      r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_count;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [6:0]  r_step;
    logic        r_final;   // this compression is the last of a finish
    logic        r_extra;   // a second padded block follows
    logic        r_need_len; // length block still to be written
    logic [2:0]  r_oidx;
    logic        r_out_valid;
    t_out_item   r_out;

    // Padding write port: one byte slot per cycle while in S_PAD.
    logic [5:0]  r_pad_pos;
    logic        r_pad_first;

    logic        in_acc;
    logic        out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // Memory write port.
    logic        mem_we;
    logic [3:0]  mem_wa;
    logic [1:0]  mem_lane;
    logic [7:0]  mem_wd;
    logic [63:0] bits;
    assign bits = {r_count[60:0], 3'b000};

    always_comb begin
        mem_we   = 1'b0;
        mem_wa   = r_fill[5:2];
        mem_lane = r_fill[1:0];
        mem_wd   = i_item.data_byte;
        if (r_state == S_IDLE && in_acc && i_item.kind == KIND_DATA) begin
            mem_we = 1'b1;
        end else if (r_state == S_PAD) begin
            mem_we   = 1'b1;
            mem_wa   = r_pad_pos[5:2];
            mem_lane = r_pad_pos[1:0];
            if (r_pad_first) begin
                mem_wd = PAD_BYTE;
            end else if (r_need_len && r_pad_pos >= 6'd56) begin
                mem_wd = bits[8'(7 - r_pad_pos[2:0]) * 8 +: 8];
            end else begin
                mem_wd = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            buf_mem[mem_wa][8'(3 - mem_lane) * 8 +: 8] <= mem_wd;
        end
        r_buf_rd <= buf_mem[r_step[3:0]];
    end

    // Round datapath.
    function automatic logic [31:0] f_ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] w_cur, w_new, t1, t2, s0, s1;
    logic [5:0]  rnd;
    assign rnd = r_step[5:0];
    always_comb begin
        s0    = f_ror(r_w[1], 7) ^ f_ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = f_ror(r_w[14], 17) ^ f_ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = r_w[0];
        t1 = r_v[7] + (f_ror(r_v[4], 6) ^ f_ror(r_v[4], 11) ^ f_ror(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + f_round_k(rnd) + w_cur;
        t2 = (f_ror(r_v[0], 2) ^ f_ror(r_v[0], 13) ^ f_ror(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_final     <= 1'b0;
            r_extra     <= 1'b0;
            r_need_len  <= 1'b0;
            r_oidx      <= '0;
            r_pad_pos   <= '0;
            r_pad_first <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= f_init_h(3'(i));
        end else begin
            // Drop the output once taken; S_EMIT decides the valid itself.
            if (out_acc && r_state != S_EMIT) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_item.kind == KIND_DATA) begin
                            r_fill  <= r_fill + 6'd1;
                            r_count <= r_count + 64'd1;
                            if (r_fill == 6'd63) begin
                                r_final <= 1'b0;
                                r_step  <= '0;
                                r_state <= S_LOAD;
                            end
                        end else begin
                            // Pad byte at fill, zero to end of block or length field.
                            r_pad_pos   <= r_fill;
                            r_pad_first <= 1'b1;
                            r_extra     <= (r_fill >= 6'd56);
                            r_need_len  <= (r_fill < 6'd56);
                            r_state     <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pad_first <= 1'b0;
                    r_pad_pos   <= r_pad_pos + 6'd1;
                    if (r_pad_pos == 6'd63) begin
                        r_final <= r_need_len;
                        r_step  <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // Memory read of word step lands in the next cycle.
                    r_step <= r_step + 7'd1;
                    if (r_step == 7'd0) begin
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end else begin
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                        r_w[15] <= r_buf_rd;
                    end
                    if (r_step == 7'd16) begin
                        r_step  <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_step <= r_step + 7'd1;
                    if (r_step == 7'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (r_extra) begin
                        // Second padded block: zeros then length.
                        r_extra     <= 1'b0;
                        r_need_len  <= 1'b1;
                        r_pad_pos   <= '0;
                        r_pad_first <= 1'b0;
                        r_state     <= S_PAD;
                    end else if (r_final) begin
                        r_oidx  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || out_acc) begin
                        r_out_valid       <= 1'b1;
                        r_out.digest_word <= r_h[r_oidx];
                        r_out.word_index  <= r_oidx;
                        r_out.last_word   <= (r_oidx == 3'd7);
                        r_oidx            <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= f_init_h(3'(i));
                            r_fill     <= '0;
                            r_count    <= '0;
                            r_final    <= 1'b0;
                            r_need_len <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: verif/sha256_byte_stream_hasher_checker.sv
// Checker for the SHA-256 byte stream hasher: watches both channels, predicts digests, compares.
// Depends on sha256_pkg for the transaction types.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_checker
    import sha256_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_stall_in,
    input  t_in_item  i_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending
);

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                       32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    logic [5:0]  fill;
    logic [63:0] byte_count;
    t_out_item   digest_q [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fold the 64 buffered bytes into the hash state.
    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        v = hash_state;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic restart();
        hash_state = IV;
        fill = '0;
        byte_count = '0;
    endtask

    // Absorb one transaction; a finish pads, compresses and queues eight digest words.
    task automatic absorb(input t_in_item it);
        logic [63:0] bits;
        int          pos;
        t_out_item   o;
        if (it.kind == KIND_DATA) begin
            block_bytes[fill] = it.data_byte;
            fill = fill + 1'b1;
            byte_count = byte_count + 64'd1;
            if (fill == 0)
                compress();
        end else begin
            bits = byte_count << 3;
            pos = int'(fill);
            block_bytes[pos] = PAD_BYTE;
            pos = pos + 1;
            if (pos > 56) begin
                while (pos < 64) begin
                    block_bytes[pos] = 8'h00;
                    pos = pos + 1;
                end
                compress();
                pos = 0;
            end
            while (pos < 56) begin
                block_bytes[pos] = 8'h00;
                pos = pos + 1;
            end
            for (int i = 0; i < 8; i++)
                block_bytes[56+i] = bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hash_state[i];
                o.word_index  = i[2:0];
                o.last_word   = (i == 7);
                digest_q.push_back(o);
            end
            restart();
        end
    endtask

    assign o_pending = digest_q.size();

    always @(posedge i_clk) begin
        t_out_item exp_word;
        if (!i_rst_n) begin
            restart();
            digest_q.delete();
            o_errors = 0;
        end else begin
            if (i_valid && !i_stall_in)
                absorb(i_item);
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected digest transaction %h", i_out_item);
                end else begin
                    exp_word = digest_q.pop_front();
                    if (exp_word !== i_out_item) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("digest mismatch: exp word %h idx %0d last %b, got %h %0d %b",
                                     exp_word.digest_word, exp_word.word_index,
                                     exp_word.last_word, i_out_item.digest_word,
                                     i_out_item.word_index, i_out_item.last_word);
                    end
                end
            end
        end
    end

endmodule

// File: verif/tb_sha256_byte_stream_hasher.sv
// Testbench top for the SHA-256 byte stream hasher: clock, reset, byte/finish stimulus, verdict.
// Depends on sha256_pkg, sha256_byte_stream_hasher and sha256_byte_stream_hasher_checker.
`timescale 1ns / 1ps
module tb_sha256_byte_stream_hasher;
    import sha256_pkg::*;

    // Idle limit covers two compressions plus eight stalled digest words with margin.
    localparam int IDLE_LIMIT = 5000;
    // Total input transactions for the run.
    localparam int ITEM_TARGET = 410;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_item = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    int        errors;
    int        pending;
    int        idle_cycles = 0;
    int        msg_items = 0;
    int        out_wait = 0;
    int        stall_mode = 0;
    int        len_set [5] = '{55, 56, 57, 63, 64};

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sha256_byte_stream_hasher dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_item  (out_item)
    );

    sha256_byte_stream_hasher_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .i_stall_in  (in_stall),
        .i_item      (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: per digest word, draw a random stall wait; some stretches never stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            out_stall <= 1'b1;
        end else if (out_valid && !out_stall) begin
            out_wait <= (stall_mode == 0) ? 0 : $urandom_range(0, 7);
            out_stall <= (stall_mode != 0) && ($urandom_range(0, 1) == 1);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Send one transaction after a random gap; hold it until accepted. Valid stays up after
    // the accepting edge so the caller either drives the next transaction or drops it.
    task automatic send(input logic kind, input logic [7:0] data, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            in_item.data_byte <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{kind: kind, data_byte: data};
        msg_items++;
        do @(posedge clk); while (in_stall);
    endtask

    // Hash a message of len bytes; mode 0 random, 1 all ones, 2 all zeros, 3 counting.
    task automatic hash_message(input int len, input int mode, input bit gaps);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (mode)
                1: b = 8'hff;
                2: b = 8'h00;
                3: b = i[7:0];
                default: b = 8'($urandom_range(0, 255));
            endcase
            send(KIND_DATA, b, gaps);
        end
        send(KIND_FINISH, 8'($urandom_range(0, 255)), gaps);
    endtask

    initial begin
        int len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, a finish with its data byte set, extreme bytes.
        send(KIND_FINISH, 8'h00, 1'b0);
        send(KIND_FINISH, 8'hff, 1'b0);
        hash_message(1, 1, 1'b0);
        hash_message(3, 2, 1'b1);
        hash_message(8, 3, 1'b0);

        // Padding boundaries: 55 fits one block, 56..63 need an extra, 64 fills exactly.
        stall_mode = 1;
        foreach (len_set[i]) hash_message(len_set[i], 0, 1'b1);

        // Random messages, mostly short, now and then spanning several blocks.
        while (msg_items < ITEM_TARGET - 10) begin
            stall_mode = $urandom_range(0, 2);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 70);
            if (len > ITEM_TARGET - 1 - msg_items)
                len = ITEM_TARGET - 1 - msg_items;
            hash_message(len, 0, stall_mode != 0);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
